FILE: sv/pnh_pkg.sv
// shared types, constants and command structs for the polyline height block
`timescale 1ns / 1ps

package pnh_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int KNOT_AW = $clog2(MAX_KNOTS);
  localparam int CNT_W = $clog2(MAX_KNOTS + 1);

  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = 104;
  localparam int LEN_W = 66;
  localparam int REM_W = LEN_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int ALPHA_W = FRAC_BITS + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;
  localparam int EX_W = 51;
  localparam int MAG_W = 50;
  localparam int HALF_W = MAG_W / 2;
  localparam int ZQ_W = 51;
  localparam int STEP_W = 31;
  localparam int NUM_W = 54;
  localparam int QM_W = NUM_W - 1;
  localparam int DVS_W = STEP_W + FRAC_BITS;
  localparam int QREM_W = DVS_W + 1;
  localparam int QS_W = QM_W + 2;
  localparam int QC_W = 33;

  localparam int DIV_STEPS = FRAC_BITS;
  localparam int QDIV_STEPS = QM_W;
  localparam int STEPC_W = $clog2(QDIV_STEPS + 1);

  localparam logic REQ_KNOT_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CFG_STANDING = 2'd0,
    CFG_LEVEL    = 2'd1,
    CFG_STEP     = 2'd2,
    CFG_COUNT    = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MUL_DXDX,
    MUL_DYDY,
    MUL_UXDX,
    MUL_UYDY,
    MUL_DXAL,
    MUL_DYAL,
    MUL_DZAL,
    MUL_XHH,
    MUL_XHL,
    MUL_XLL,
    MUL_YHH,
    MUL_YHL,
    MUL_YLL,
    MUL_QSTEP
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_MID,
    SH_HIGH
  } acc_sh_t;

  typedef struct packed {
    logic               knot_wr;
    logic               query_load;
    logic [KNOT_AW-1:0] rd_addr;
    logic               cap_start;
    logic               cap_diff;
    mul_sel_t           mul_sel;
    acc_op_t            acc_op;
    acc_sh_t            acc_sh;
    logic               cap_len2;
    logic               div_init;
    logic               div_step;
    logic               cap_ex;
    logic               cap_ey;
    logic               cap_zint;
    logic               cap_mag;
    logic               init_best;
    logic               seg_cmp;
    logic               q_init;
    logic               qd_init;
    logic               qd_step;
    logic               q_fix;
    logic               out_load;
    logic               out_stand;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/polyline_nearest_height.sv
// top level: configuration registers, sequencer and datapath
`timescale 1ns / 1ps

// Water surface height at a query point. An item with req_type 0 writes knot
// (x, y, z) at knot_index and gives no result; an item with req_type 1
// returns one surface_z. In standing mode a query returns water_level.
// Otherwise the block walks the n-1 segments, n being the clamped knot
// count, projects the point on each, keeps the first nearest one,
// interpolates z and rounds it to a multiple of height_step, saturated.
// A flowing query is slowed by the single shared multiplier, which every
// segment uses thirteen times, by the one-bit-a-cycle fraction divider and
// by the serial divider of the quantizer. The knot tables are memories with
// one write and one read port, read one knot a cycle. A new item is taken
// once the query in work has placed its result in the output register;
// that result may still wait there for out_ready. Knots read by a query
// must have been written.
module polyline_nearest_height (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [5:0]         knot_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] knot_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] surface_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import pnh_pkg::*;

  // configuration registers
  logic                standing_mode;
  logic signed [31:0]  water_level;
  logic [STEP_W-1:0]   height_step;
  logic [6:0]          knot_count;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // plain write port, taken whenever the enable is high
  always_ff @(posedge clk) begin
    if (rst) begin
      standing_mode <= 1'b0;
      water_level <= '0;
      height_step <= STEP_W'(256);
      knot_count <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STANDING: standing_mode <= cfg_wdata[0];
        CFG_LEVEL:    water_level <= cfg_wdata;
        CFG_STEP:     height_step <= cfg_wdata[STEP_W-1:0];
        CFG_COUNT:    knot_count <= cfg_wdata[6:0];
        default:      standing_mode <= standing_mode;
      endcase
    end
  end

  // segment walk and quantizer sequencing
  pnh_controller u_ctl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .standing_mode (standing_mode),
    .knot_count    (knot_count),
    .status        (status),
    .cmd           (cmd)
  );

  // knot memories, multiplier, dividers and output register
  pnh_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .knot_index  (knot_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .knot_z      (knot_z),
    .water_level (water_level),
    .height_step (height_step),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .surface_z   (surface_z)
  );

endmodule

FILE: sv/pnh_datapath.sv
// knot tables, shared multiplier, accumulator and serial dividers
`timescale 1ns / 1ps

module pnh_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  pnh_pkg::dp_cmd_t            cmd,
  output pnh_pkg::dp_status_t         status,
  input  logic [5:0]                  knot_index,
  input  logic signed [31:0]          coord_x,
  input  logic signed [31:0]          coord_y,
  input  logic signed [31:0]          knot_z,
  input  logic signed [31:0]          water_level,
  input  logic [pnh_pkg::STEP_W-1:0]  height_step,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [31:0]          surface_z
);
  import pnh_pkg::*;

  logic signed [COORD_W-1:0] mem_x [MAX_KNOTS];
  logic signed [COORD_W-1:0] mem_y [MAX_KNOTS];
  logic signed [COORD_W-1:0] mem_z [MAX_KNOTS];
  logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
  logic wr_ok;
  logic [KNOT_AW-1:0] wr_addr;

  logic signed [COORD_W-1:0] qx, qy, sx, sy, sz;
  logic signed [DIFF_W-1:0] dx, dy, dz, ux, uy;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, acc_term, best;
  logic [LEN_W-1:0] len2;
  logic [REM_W-1:0] r, r2;
  logic [ALPHA_W-1:0] alpha;
  logic dskip;
  logic signed [EX_W-1:0] ex, ey;
  logic [MAG_W-1:0] exm, eym;
  logic signed [ZQ_W-1:0] zint, best_z;
  logic have;
  logic [STEP_W-1:0] stepn;
  logic signed [NUM_W-1:0] num;
  logic [DVS_W-1:0] dvs;
  logic nneg;
  logic [QM_W-1:0] qm;
  logic [QREM_W-1:0] qrem, rs;
  logic signed [QS_W-1:0] qs;
  logic signed [QC_W-1:0] qc;

  assign wr_ok = 32'(knot_index) < MAX_KNOTS;
  assign wr_addr = KNOT_AW'(knot_index);

  always_ff @(posedge clk) begin
    if (cmd.knot_wr && wr_ok) begin
      mem_x[wr_addr] <= coord_x;
      mem_y[wr_addr] <= coord_y;
      mem_z[wr_addr] <= knot_z;
    end
    rd_x <= mem_x[cmd.rd_addr];
    rd_y <= mem_y[cmd.rd_addr];
    rd_z <= mem_z[cmd.rd_addr];
  end

  assign stepn = (height_step == '0) ? STEP_W'(1) : height_step;

  always_comb begin
    mul_a = MUL_W'(dx);
    mul_b = MUL_W'(dx);
    case (cmd.mul_sel)
      MUL_DXDX: begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
      MUL_DYDY: begin mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); end
      MUL_UXDX: begin mul_a = MUL_W'(ux); mul_b = MUL_W'(dx); end
      MUL_UYDY: begin mul_a = MUL_W'(uy); mul_b = MUL_W'(dy); end
      MUL_DXAL: begin mul_a = MUL_W'(dx); mul_b = $signed(MUL_W'(alpha)); end
      MUL_DYAL: begin mul_a = MUL_W'(dy); mul_b = $signed(MUL_W'(alpha)); end
      MUL_DZAL: begin mul_a = MUL_W'(dz); mul_b = $signed(MUL_W'(alpha)); end
      MUL_XHH: begin
        mul_a = $signed(MUL_W'(exm[MAG_W-1:HALF_W]));
        mul_b = $signed(MUL_W'(exm[MAG_W-1:HALF_W]));
      end
      MUL_XHL: begin
        mul_a = $signed(MUL_W'(exm[MAG_W-1:HALF_W]));
        mul_b = $signed(MUL_W'(exm[HALF_W-1:0]));
      end
      MUL_XLL: begin
        mul_a = $signed(MUL_W'(exm[HALF_W-1:0]));
        mul_b = $signed(MUL_W'(exm[HALF_W-1:0]));
      end
      MUL_YHH: begin
        mul_a = $signed(MUL_W'(eym[MAG_W-1:HALF_W]));
        mul_b = $signed(MUL_W'(eym[MAG_W-1:HALF_W]));
      end
      MUL_YHL: begin
        mul_a = $signed(MUL_W'(eym[MAG_W-1:HALF_W]));
        mul_b = $signed(MUL_W'(eym[HALF_W-1:0]));
      end
      MUL_YLL: begin
        mul_a = $signed(MUL_W'(eym[HALF_W-1:0]));
        mul_b = $signed(MUL_W'(eym[HALF_W-1:0]));
      end
      MUL_QSTEP: begin mul_a = MUL_W'(qc); mul_b = $signed(MUL_W'(stepn)); end
      default: begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
    endcase
  end

  // cross term of a square is doubled, hence one more bit of shift
  always_comb begin
    case (cmd.acc_sh)
      SH_MID:  acc_term = ACC_W'(prod) <<< (HALF_W + 1);
      SH_HIGH: acc_term = ACC_W'(prod) <<< (2 * HALF_W);
      default: acc_term = ACC_W'(prod);
    endcase
  end

  assign r2 = {r[REM_W-2:0], 1'b0};
  assign rs = {qrem[QREM_W-2:0], qm[QM_W-1]};

  always_comb begin
    if (nneg) begin
      qs = -$signed(QS_W'(qm)) - QS_W'(qrem != '0);
    end else begin
      qs = $signed(QS_W'(qm));
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.acc_op)
      ACC_LOAD: acc <= acc_term;
      ACC_ADD:  acc <= acc + acc_term;
      default:  acc <= acc;
    endcase
    if (cmd.query_load) begin
      qx <= coord_x;
      qy <= coord_y;
    end
    if (cmd.cap_start) begin
      sx <= rd_x;
      sy <= rd_y;
      sz <= rd_z;
    end
    if (cmd.cap_diff) begin
      dx <= DIFF_W'(rd_x) - DIFF_W'(sx);
      dy <= DIFF_W'(rd_y) - DIFF_W'(sy);
      dz <= DIFF_W'(rd_z) - DIFF_W'(sz);
      ux <= DIFF_W'(qx) - DIFF_W'(sx);
      uy <= DIFF_W'(qy) - DIFF_W'(sy);
    end
    if (cmd.cap_len2) begin
      len2 <= acc[LEN_W-1:0];
    end
    // acc holds the dot product here
    if (cmd.div_init) begin
      r <= REM_W'(acc[LEN_W-1:0]);
      if (len2 == '0 || acc[ACC_W-1] || acc == '0) begin
        alpha <= '0;
        dskip <= 1'b1;
      end else if (acc >= ACC_W'(len2)) begin
        alpha <= ALPHA_ONE;
        dskip <= 1'b1;
      end else begin
        alpha <= '0;
        dskip <= 1'b0;
      end
    end
    if (cmd.div_step && !dskip) begin
      if (r2 >= REM_W'(len2)) begin
        r <= r2 - REM_W'(len2);
        alpha <= {alpha[ALPHA_W-2:0], 1'b1};
      end else begin
        r <= r2;
        alpha <= {alpha[ALPHA_W-2:0], 1'b0};
      end
    end
    if (cmd.cap_ex) begin
      ex <= (EX_W'(ux) <<< FRAC_BITS) - EX_W'(prod);
    end
    if (cmd.cap_ey) begin
      ey <= (EX_W'(uy) <<< FRAC_BITS) - EX_W'(prod);
    end
    if (cmd.cap_zint) begin
      zint <= (ZQ_W'(sz) <<< FRAC_BITS) + ZQ_W'(prod);
    end
    if (cmd.cap_mag) begin
      exm <= ex[EX_W-1] ? MAG_W'(-ex) : MAG_W'(ex);
      eym <= ey[EX_W-1] ? MAG_W'(-ey) : MAG_W'(ey);
    end
    if (cmd.init_best) begin
      best_z <= ZQ_W'(rd_z) <<< FRAC_BITS;
      have <= 1'b0;
    end
    if (cmd.seg_cmp && (!have || acc < best)) begin
      best <= acc;
      best_z <= zint;
      have <= 1'b1;
    end
    if (cmd.q_init) begin
      num <= NUM_W'(best_z) + $signed(NUM_W'({stepn, 15'b0}));
      dvs <= {stepn, {FRAC_BITS{1'b0}}};
    end
    if (cmd.qd_init) begin
      nneg <= num[NUM_W-1];
      qm <= num[NUM_W-1] ? QM_W'(-num) : QM_W'(num);
      qrem <= '0;
    end
    if (cmd.qd_step) begin
      if (rs >= QREM_W'(dvs)) begin
        qrem <= rs - QREM_W'(dvs);
        qm <= {qm[QM_W-2:0], 1'b1};
      end else begin
        qrem <= rs;
        qm <= {qm[QM_W-2:0], 1'b0};
      end
    end
    // any quotient beyond 33 bits saturates after the step multiply anyway
    if (cmd.q_fix) begin
      if (qs > $signed(QS_W'(33'h0_FFFF_FFFF))) begin
        qc <= $signed({1'b0, {(QC_W-1){1'b1}}});
      end else if (qs < -$signed(QS_W'(33'h1_0000_0000))) begin
        qc <= $signed({1'b1, {(QC_W-1){1'b0}}});
      end else begin
        qc <= qs[QC_W-1:0];
      end
    end
    if (cmd.out_load) begin
      if (prod > $signed(PROD_W'(32'h7FFF_FFFF))) begin
        surface_z <= 32'sh7FFF_FFFF;
      end else if (prod < -$signed(PROD_W'(33'h0_8000_0000))) begin
        surface_z <= 32'sh8000_0000;
      end else begin
        surface_z <= prod[31:0];
      end
    end else if (cmd.out_stand) begin
      surface_z <= water_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_stand) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_dist_nonneg: assert property (@(posedge clk) disable iff (rst)
    cmd.seg_cmp |-> !acc[ACC_W-1])
    else $error("segment distance negative");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && !dskip) |-> (r < REM_W'(len2)))
    else $error("fraction remainder out of range");
  a_qdiv_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.q_fix |-> (qrem < QREM_W'(dvs)))
    else $error("quantizer remainder out of range");
`endif

endmodule

FILE: sv/pnh_controller.sv
// sequencer that walks segments and drives the datapath
`timescale 1ns / 1ps

module pnh_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic                       standing_mode,
  input  logic [6:0]                 knot_count,
  input  pnh_pkg::dp_status_t        status,
  output pnh_pkg::dp_cmd_t           cmd
);
  import pnh_pkg::*;

  typedef enum logic [34:0] {
    S_IDLE    = 35'd1 << 0,
    S_STAND   = 35'd1 << 1,
    S_INIT_RD = 35'd1 << 2,
    S_INIT_LD = 35'd1 << 3,
    S_RDA     = 35'd1 << 4,
    S_RDB     = 35'd1 << 5,
    S_LDD     = 35'd1 << 6,
    S_M1      = 35'd1 << 7,
    S_M2      = 35'd1 << 8,
    S_M3      = 35'd1 << 9,
    S_M4      = 35'd1 << 10,
    S_M5      = 35'd1 << 11,
    S_DV0     = 35'd1 << 12,
    S_DIV     = 35'd1 << 13,
    S_M6      = 35'd1 << 14,
    S_M7      = 35'd1 << 15,
    S_M8      = 35'd1 << 16,
    S_M9      = 35'd1 << 17,
    S_Q1      = 35'd1 << 18,
    S_Q2      = 35'd1 << 19,
    S_Q3      = 35'd1 << 20,
    S_Q4      = 35'd1 << 21,
    S_Q5      = 35'd1 << 22,
    S_Q6      = 35'd1 << 23,
    S_Q7      = 35'd1 << 24,
    S_CMP     = 35'd1 << 25,
    S_QN      = 35'd1 << 26,
    S_QD0     = 35'd1 << 27,
    S_QDIV    = 35'd1 << 28,
    S_QFIX    = 35'd1 << 29,
    S_QMUL    = 35'd1 << 30,
    S_QSAT    = 35'd1 << 31
  } state_t;

  state_t state, state_next;
  logic [KNOT_AW-1:0] seg, seg_next;
  logic [STEPC_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] n;
  logic in_fire;

  // zero knots act as one, counts above the table clamp to its depth
  always_comb begin
    if (knot_count == '0) begin
      n = CNT_W'(1);
    end else if (32'(knot_count) > MAX_KNOTS) begin
      n = CNT_W'(MAX_KNOTS);
    end else begin
      n = CNT_W'(knot_count);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_next = state;
    seg_next = seg;
    cnt_next = cnt;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (req_type == REQ_KNOT_WRITE) begin
            cmd.knot_wr = 1'b1;
          end else begin
            cmd.query_load = 1'b1;
            seg_next = '0;
            state_next = standing_mode ? S_STAND : S_INIT_RD;
          end
        end
      end
      S_STAND: begin
        if (status.out_free) begin
          cmd.out_stand = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INIT_RD: begin
        cmd.rd_addr = '0;
        state_next = S_INIT_LD;
      end
      S_INIT_LD: begin
        cmd.init_best = 1'b1;
        state_next = (n > CNT_W'(1)) ? S_RDA : S_QN;
      end
      S_RDA: begin
        cmd.rd_addr = seg;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rd_addr = seg + 1'b1;
        cmd.cap_start = 1'b1;
        state_next = S_LDD;
      end
      S_LDD: begin
        cmd.cap_diff = 1'b1;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = MUL_DXDX;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = MUL_DYDY;
        cmd.acc_op = ACC_LOAD;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.mul_sel = MUL_UXDX;
        cmd.acc_op = ACC_ADD;
        state_next = S_M4;
      end
      S_M4: begin
        cmd.mul_sel = MUL_UYDY;
        cmd.acc_op = ACC_LOAD;
        cmd.cap_len2 = 1'b1;
        state_next = S_M5;
      end
      S_M5: begin
        cmd.acc_op = ACC_ADD;
        state_next = S_DV0;
      end
      S_DV0: begin
        cmd.div_init = 1'b1;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == STEPC_W'(DIV_STEPS - 1)) begin
          state_next = S_M6;
        end
      end
      S_M6: begin
        cmd.mul_sel = MUL_DXAL;
        state_next = S_M7;
      end
      S_M7: begin
        cmd.mul_sel = MUL_DYAL;
        cmd.cap_ex = 1'b1;
        state_next = S_M8;
      end
      S_M8: begin
        cmd.mul_sel = MUL_DZAL;
        cmd.cap_ey = 1'b1;
        state_next = S_M9;
      end
      S_M9: begin
        cmd.cap_zint = 1'b1;
        cmd.cap_mag = 1'b1;
        state_next = S_Q1;
      end
      S_Q1: begin
        cmd.mul_sel = MUL_XHH;
        state_next = S_Q2;
      end
      S_Q2: begin
        cmd.mul_sel = MUL_XHL;
        cmd.acc_op = ACC_LOAD;
        cmd.acc_sh = SH_HIGH;
        state_next = S_Q3;
      end
      S_Q3: begin
        cmd.mul_sel = MUL_XLL;
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = SH_MID;
        state_next = S_Q4;
      end
      S_Q4: begin
        cmd.mul_sel = MUL_YHH;
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = SH_0;
        state_next = S_Q5;
      end
      S_Q5: begin
        cmd.mul_sel = MUL_YHL;
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = SH_HIGH;
        state_next = S_Q6;
      end
      S_Q6: begin
        cmd.mul_sel = MUL_YLL;
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = SH_MID;
        state_next = S_Q7;
      end
      S_Q7: begin
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = SH_0;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.seg_cmp = 1'b1;
        if (32'(seg) + 2 < 32'(n)) begin
          seg_next = seg + 1'b1;
          state_next = S_RDA;
        end else begin
          state_next = S_QN;
        end
      end
      S_QN: begin
        cmd.q_init = 1'b1;
        state_next = S_QD0;
      end
      S_QD0: begin
        cmd.qd_init = 1'b1;
        cnt_next = '0;
        state_next = S_QDIV;
      end
      S_QDIV: begin
        cmd.qd_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == STEPC_W'(QDIV_STEPS - 1)) begin
          state_next = S_QFIX;
        end
      end
      S_QFIX: begin
        cmd.q_fix = 1'b1;
        state_next = S_QMUL;
      end
      S_QMUL: begin
        cmd.mul_sel = MUL_QSTEP;
        state_next = S_QSAT;
      end
      S_QSAT: begin
        // keep the step product in place while the output register is busy
        cmd.mul_sel = MUL_QSTEP;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      seg <= seg_next;
      cnt <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (32'(seg) + 1 < 32'(n)))
    else $error("segment index past last knot");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt < STEPC_W'(DIV_STEPS)))
    else $error("fraction divider ran too long");
  a_out_only_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load || cmd.out_stand) |-> status.out_free)
    else $error("result written over an untaken item");
`endif

endmodule
